[rtl/mmn_pkg.sv]
// Package for the min-max frame normalizer.
// Holds command codes, the Q8.8 scale constants and the divider result type.
// No dependencies.
package mmn_pkg;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EMIT = 1'b1
   } cmd_type;

   // Width of the Q8.8 result and of the divider quotient
   localparam int Q_BITS    = 16;
   localparam int STEP_BITS = $clog2(Q_BITS);

   // Full scale 255.0 in Q8.8: 65280 = 2^16 - 2^8
   localparam logic [Q_BITS-1:0] Q_FULL = 16'hFF00;
   localparam int SCALE_HI_SHIFT = 16;
   localparam int SCALE_LO_SHIFT = 8;

   typedef struct packed {
      logic              done;
      logic [Q_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/min_max_normalize_frame.sv]
// Channel   Handshake          Payload
// request   start / busy       req_cmd, req_sample, req_frame_end
// result    rsp_valid strobe   rsp_scaled, rsp_last, rsp_flat
//
// Loads can come back to back: sample written to the frame RAM, min/max
// updated in place. An emit runs through a RAM read, operand setup, 16 steps
// of the bit-serial divider and the result register; a flat frame skips the
// divider. The divider sets the emit rate. Reset is synchronous and empties
// the frame; the RAM needs no clearing. Results show for one cycle and
// cannot be held off; busy is low while a result is on the ports.
module min_max_normalize_frame
   import mmn_pkg::*;
#(
   parameter int FRAME_DEPTH = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_frame_end,
   output logic                          rsp_valid,
   output logic [Q_BITS-1:0]             rsp_scaled,
   output logic                          rsp_last,
   output logic                          rsp_flat
);

   localparam int AW = $clog2(FRAME_DEPTH);
   localparam int CW = $clog2(FRAME_DEPTH + 1);
   localparam int NW = SAMPLE_BITS + Q_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE
   } state_type;

   state_type                      state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0]  min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0]  max_ff, max_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  index_ff, index_in;
   logic                           ready_ff, ready_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [Q_BITS-1:0]              rsp_scaled_ff, rsp_scaled_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_flat_ff, rsp_flat_in;

   logic                           accept;
   logic                           load_ok;
   logic [CW-1:0]                  count_next;
   logic [CW-1:0]                  index_next;
   logic signed [SAMPLE_BITS-1:0]  rd_sample;
   logic [SAMPLE_BITS-1:0]         offset;
   logic [SAMPLE_BITS-1:0]         span;
   logic [NW-1:0]                  numer;
   logic                           div_go;
   div_rsp_type                    div_rsp;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign load_ok    = accept && (req_cmd == CMD_LOAD) && !ready_ff &&
                       (count_ff < CW'(FRAME_DEPTH));
   assign count_next = count_ff + 1'b1;
   assign index_next = index_ff + 1'b1;

   mmn_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr (index_ff[AW-1:0]),
      .rd_data (rd_sample)
   );

   // x - min and max - min are never negative and fit SAMPLE_BITS unsigned
   assign offset = SAMPLE_BITS'(rd_sample - min_ff);
   assign span   = SAMPLE_BITS'(max_ff - min_ff);
   // offset * 65280 + span / 2, rounding to nearest
   assign numer  = (NW'(offset) << SCALE_HI_SHIFT) - (NW'(offset) << SCALE_LO_SHIFT) +
                   NW'(span >> 1);

   mmn_div #(
      .DEN_BITS (SAMPLE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (numer),
      .den   (span),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      count_in      = count_ff;
      index_in      = index_ff;
      ready_in      = ready_ff;
      rsp_valid_in  = 1'b0;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_flat_in   = rsp_flat_ff;
      div_go        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (load_ok) begin
               if (req_sample < min_ff) begin
                  min_in = req_sample;
               end
               if (req_sample > max_ff) begin
                  max_in = req_sample;
               end
               count_in = count_next;
               if (req_frame_end || (count_next == CW'(FRAME_DEPTH))) begin
                  ready_in = 1'b1;
               end
            end else if (accept && (req_cmd == CMD_EMIT) && ready_ff) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rsp_last_in = (index_next >= count_ff);
            rsp_flat_in = (max_ff <= min_ff);
            index_in    = index_next;
            if (max_ff <= min_ff) begin
               rsp_scaled_in = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               div_go   = 1'b1;
               state_in = ST_DIVIDE;
            end
            // Close out the frame on its final emit
            if (index_next >= count_ff) begin
               min_in   = MIN_RESET;
               max_in   = MAX_RESET;
               count_in = '0;
               index_in = '0;
               ready_in = 1'b0;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               rsp_scaled_in = div_rsp.quotient;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_flat_ff   <= rsp_flat_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         count_ff     <= '0;
         index_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_scaled = rsp_scaled_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_flat   = rsp_flat_ff;

endmodule

[rtl/mmn_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mmn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/mmn_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on mmn_pkg; the quotient must fit in Q_BITS bits.
module mmn_div
   import mmn_pkg::*;
#(
   parameter int DEN_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [DEN_BITS+Q_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]        den,
   output div_rsp_type                rsp
);

   localparam int NW = DEN_BITS + Q_BITS;

   logic [NW-1:0]        rem_ff, rem_in;
   logic [NW-1:0]        dsh_ff, dsh_in;
   logic [Q_BITS-1:0]    quo_ff, quo_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 fits;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      fits    = (rem_ff >= dsh_ff);
      if (go) begin
         rem_in  = num;
         dsh_in  = NW'(den) << (Q_BITS - 1);
         quo_in  = '0;
         step_in = STEP_BITS'(Q_BITS - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[Q_BITS-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[rtl/mmn_checker.sv]
// Port-level checks for the min-max frame normalizer, bound to the top level.
// Depends on mmn_pkg and min_max_normalize_frame.
module mmn_checker
   import mmn_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_cmd,
   input logic              rsp_valid,
   input logic [Q_BITS-1:0] rsp_scaled,
   input logic              rsp_flat
);

   // A new emit must be accepted in idle and pass through the fetch state, so results never come back to back
   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // A load never makes the block busy or produces a result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load caused busy or a result");

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flat) |-> (rsp_scaled == '0))
      else $error("flat frame result is not zero");

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scaled <= Q_FULL))
      else $error("result above full scale");

endmodule

bind min_max_normalize_frame mmn_checker u_mmn_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_cmd    (req_cmd),
   .rsp_valid  (rsp_valid),
   .rsp_scaled (rsp_scaled),
   .rsp_flat   (rsp_flat)
);
